[sv/qsu_pkg.sv]
// qsu_pkg: shared types and codes for the quoted-string unescaper.
// Depends on nothing; imported by every module of the block.
package qsu_pkg;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_RAW_LF   = 3'd1;
   localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
   localparam logic [2:0] ERR_NUL      = 3'd4;
   localparam logic [2:0] ERR_NO_QUOTE = 3'd5;

   localparam logic [15:0] LINES_MAX = 16'hFFFF;

   // Results raised by one source byte: up to three, all sharing kind,
   // error code and line count.  Only data results come in groups.
   typedef struct packed {
      logic [1:0]  count;
      logic [1:0]  kind;
      logic [2:0]  error_code;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [15:0] line_breaks;
   } bundle_type;

endpackage

[sv/qsu_front.sv]
// qsu_front: accepts source bytes and decodes them into result bundles.
// Depends on qsu_pkg.
module qsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         byte_in,
   output logic               bundle_valid,
   output qsu_pkg::bundle_type bundle
);
   import qsu_pkg::*;

   typedef enum logic [2:0] {
      MODE_WAIT = 3'd0,
      MODE_BODY = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX  = 3'd3,
      MODE_CR   = 3'd4
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  digits_ff, digits_in;
   logic [15:0] lines_ff, lines_in;
   logic [15:0] lines_bumped;
   logic [15:0] code_point;
   logic [3:0]  hex_digit;
   logic        hex_ok;
   logic [7:0]  byte_up;
   bundle_type  bun;

   always_comb begin
      byte_up = byte_in & 8'hDF;
      hex_ok = 1'b1;
      hex_digit = 4'd0;
      if (byte_in inside {[8'h30 : 8'h39]}) begin
         hex_digit = byte_in[3:0];
      end else if (byte_up inside {[8'h41 : 8'h46]}) begin
         hex_digit = 4'(byte_up[3:0] + 4'd9);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign lines_bumped = (lines_ff == LINES_MAX) ? lines_ff : 16'(lines_ff + 16'd1);
   assign code_point = {acc_ff[11:0], hex_digit};

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      lines_in  = lines_ff;
      bun       = '0;
      case (mode_ff)
         MODE_BODY, MODE_CR: begin
            if (mode_ff == MODE_CR && byte_in == 8'h0A) begin
               mode_in = MODE_BODY;
            end else if (byte_in == 8'h22) begin
               mode_in = MODE_WAIT;
               bun.count = 2'd1;
               bun.kind = KIND_END;
            end else if (byte_in == 8'h0A) begin
               mode_in = MODE_WAIT;
               bun.count = 2'd1;
               bun.kind = KIND_ERROR;
               bun.error_code = ERR_RAW_LF;
            end else if (byte_in == 8'h00) begin
               mode_in = MODE_WAIT;
               bun.count = 2'd1;
               bun.kind = KIND_ERROR;
               bun.error_code = ERR_NUL;
            end else if (byte_in == 8'h5C) begin
               mode_in = MODE_ESC;
            end else begin
               mode_in = MODE_BODY;
               bun.count = 2'd1;
               bun.byte0 = byte_in;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_BODY;
            bun.count = 2'd1;
            case (byte_in)
               8'h6E: bun.byte0 = 8'h0A;
               8'h74: bun.byte0 = 8'h09;
               8'h62: bun.byte0 = 8'h08;
               8'h72: bun.byte0 = 8'h0D;
               8'h66: bun.byte0 = 8'h0C;
               8'h61: bun.byte0 = 8'h07;
               8'h5C, 8'h3F, 8'h27, 8'h22: bun.byte0 = byte_in;
               8'h75: begin
                  mode_in = MODE_HEX;
                  acc_in = '0;
                  digits_in = '0;
                  bun.count = 2'd0;
               end
               8'h0A: begin
                  lines_in = lines_bumped;
                  bun.count = 2'd0;
               end
               8'h0D: begin
                  lines_in = lines_bumped;
                  mode_in = MODE_CR;
                  bun.count = 2'd0;
               end
               default: begin
                  mode_in = MODE_WAIT;
                  bun.kind = KIND_ERROR;
                  bun.error_code = ERR_BAD_ESC;
               end
            endcase
         end
         MODE_HEX: begin
            if (!hex_ok) begin
               mode_in = MODE_WAIT;
               bun.count = 2'd1;
               bun.kind = KIND_ERROR;
               bun.error_code = ERR_BAD_HEX;
            end else if (digits_ff != 2'd3) begin
               acc_in = code_point;
               digits_in = 2'(digits_ff + 2'd1);
            end else begin
               acc_in = code_point;
               digits_in = '0;
               mode_in = MODE_BODY;
               // pick the UTF-8 length from the top bits of the code point
               if (code_point[15:7] == '0) begin
                  bun.count = 2'd1;
                  bun.byte0 = code_point[7:0];
               end else if (code_point[15:11] == '0) begin
                  bun.count = 2'd2;
                  bun.byte0 = {3'b110, code_point[10:6]};
                  bun.byte1 = {2'b10, code_point[5:0]};
               end else begin
                  bun.count = 2'd3;
                  bun.byte0 = {4'b1110, code_point[15:12]};
                  bun.byte1 = {2'b10, code_point[11:6]};
                  bun.byte2 = {2'b10, code_point[5:0]};
               end
            end
         end
         default: begin
            if (byte_in == 8'h22) begin
               mode_in = MODE_BODY;
            end else begin
               mode_in = MODE_WAIT;
               bun.count = 2'd1;
               bun.kind = KIND_ERROR;
               bun.error_code = ERR_NO_QUOTE;
            end
         end
      endcase
      bun.line_breaks = lines_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_WAIT;
         acc_ff    <= '0;
         digits_ff <= '0;
         lines_ff  <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         lines_ff  <= lines_in;
      end
   end

   assign bundle_valid = accept && (bun.count != 2'd0);
   assign bundle = bun;

endmodule

[sv/qsu_queue.sv]
// qsu_queue: short first-in first-out store of result bundles.
// Depends on qsu_pkg.
module qsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               write_en,
   input  qsu_pkg::bundle_type write_data,
   input  logic               read_en,
   output qsu_pkg::bundle_type read_data,
   output logic               not_empty,
   output logic               full
);
   import qsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   bundle_type       store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign not_empty = (count_ff != '0);
   assign full = (count_ff == CNT_FULL);
   assign read_data = store[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (write_en) begin
         store[wr_ptr_ff] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (write_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (read_en) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (write_en && !read_en) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end else if (read_en && !write_en) begin
            count_ff <= CNT_W'(count_ff - 1'b1);
         end
      end
   end

endmodule

[sv/qsu_back.sv]
// qsu_back: output register that hands out one result word per pop.
// Depends on qsu_pkg.
module qsu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_not_empty,
   input  qsu_pkg::bundle_type queue_data,
   output logic               queue_read,
   input  logic               pop,
   output logic               empty,
   output logic [1:0]         kind,
   output logic [7:0]         data_byte,
   output logic [2:0]         error_code,
   output logic               last,
   output logic [15:0]        line_breaks
);
   import qsu_pkg::*;

   bundle_type bun_ff;
   logic       valid_ff;
   logic [1:0] index_ff;
   logic       on_last;
   logic       taken;

   assign on_last = (index_ff == 2'(bun_ff.count - 2'd1));
   assign taken = valid_ff && pop;
   // refill when idle or when the final word of the held bundle leaves
   assign queue_read = queue_not_empty && (!valid_ff || (taken && on_last));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= '0;
      end else if (queue_read) begin
         valid_ff <= 1'b1;
         index_ff <= '0;
      end else if (taken) begin
         if (on_last) begin
            valid_ff <= 1'b0;
         end else begin
            index_ff <= 2'(index_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_read) begin
         bun_ff <= queue_data;
      end
   end

   always_comb begin
      case (index_ff)
         2'd0:    data_byte = bun_ff.byte0;
         2'd1:    data_byte = bun_ff.byte1;
         default: data_byte = bun_ff.byte2;
      endcase
   end

   assign empty = !valid_ff;
   assign kind = bun_ff.kind;
   assign error_code = bun_ff.error_code;
   assign last = on_last;
   assign line_breaks = bun_ff.line_breaks;

endmodule

[sv/quoted_string_unescape_utf8.sv]
// quoted_string_unescape_utf8: top level of the quoted-string unescaper.
// Depends on qsu_pkg, qsu_front, qsu_queue and qsu_back.
//
//   channel   direction  handshake     word
//   req_      in         push / full   one raw source byte
//   rsp_      out        empty / pop   one result: kind, byte, error, last, lines
//
// One source byte is taken every cycle with req_push high and req_full low; the
// decoder works it in that cycle and files zero to three results as one bundle in
// a queue of QUEUE_DEPTH. The output register hands out one result per cycle while
// rsp_pop is high, so a \u escape's bytes leave while later bytes are decoded.
// full rises only when the queue is full; a stalled pop holds the word shown.
// Reset is synchronous and returns the decoder to waiting for a quote.
module quoted_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last,
   output logic [15:0] rsp_line_breaks
);
   import qsu_pkg::*;

   logic       accept;
   logic       front_valid;
   bundle_type front_bundle;
   bundle_type queue_data;
   logic       queue_not_empty;
   logic       queue_full;
   logic       queue_read;

   assign accept = req_push && !queue_full;
   assign req_full = queue_full;

   qsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_in      (req_byte_in),
      .bundle_valid (front_valid),
      .bundle       (front_bundle)
   );

   qsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .write_en   (front_valid),
      .write_data (front_bundle),
      .read_en    (queue_read),
      .read_data  (queue_data),
      .not_empty  (queue_not_empty),
      .full       (queue_full)
   );

   qsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_data      (queue_data),
      .queue_read      (queue_read),
      .pop             (rsp_pop),
      .empty           (rsp_empty),
      .kind            (rsp_kind),
      .data_byte       (rsp_data_byte),
      .error_code      (rsp_error_code),
      .last            (rsp_last),
      .line_breaks     (rsp_line_breaks)
   );

endmodule
